>>> rtl/tlfp_pkg.sv
`default_nettype none

package tlfp_pkg;

   // Width of the stored counts and of the field magnitude accumulator.
   localparam int VALUE_WIDTH = 32;
   // Width of the count fields on the result channel.
   localparam int OUT_WIDTH = 32;
   // Depth of the line queue between the byte front end and the update back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Largest magnitude a field may reach (a negative field may reach it exactly).
   localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] MAG_DIV10 = MAG_LIMIT / 10;
   localparam logic [3:0] MAG_MOD10 = 4'(MAG_LIMIT % 10);

   // Characters with a meaning to the line framing.
   localparam logic [7:0] CH_NL = 8'd10;
   localparam logic [7:0] CH_SEP = 8'd59;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_ENC = 2'd1,
      KIND_TIME = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_NO_DIGITS = 2'd1,
      ST_RANGE = 2'd2,
      ST_NOT_APPLIED = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      logic [1:0]                 line_kind;
      logic signed [OUT_WIDTH-1:0] left_count;
      logic signed [OUT_WIDTH-1:0] right_count;
      logic signed [OUT_WIDTH-1:0] update_micros;
      logic signed [OUT_WIDTH-1:0] since_seconds;
      logic [1:0]                 first_status;
      logic [1:0]                 second_status;
   } rsp_type;

   // Running state of one numeric field.
   typedef struct packed {
      logic                   minus;
      logic                   digit;
      logic                   ovf;
      logic [VALUE_WIDTH-1:0] mag;
   } parse_state_type;

   typedef struct packed {
      status_type             status;
      logic [VALUE_WIDTH-1:0] value;
   } finish_type;

   // One finished line, handed from the front end to the back end.
   typedef struct packed {
      kind_type               kind;
      logic                   applied;
      status_type             first_status;
      logic [VALUE_WIDTH-1:0] first_value;
      parse_state_type        field2;
   } line_rec_type;

   // Turns the running state of a field into its value and status.
   function automatic finish_type parse_finish(input parse_state_type ps);
      finish_type r;
      r.value = ps.minus ? (VALUE_WIDTH'(0) - ps.mag) : ps.mag;
      if (!ps.digit) begin
         r.status = ST_NO_DIGITS;
      end else if (ps.ovf) begin
         r.status = ST_RANGE;
      end else if (ps.minus ? (ps.mag > MAG_LIMIT) : (ps.mag > (MAG_LIMIT - 1'b1))) begin
         r.status = ST_RANGE;
      end else begin
         r.status = ST_OK;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/telemetry_line_field_parser.sv
// Telemetry line field parser.
// The req channel carries one received byte per transaction with a chunk_end
// flag. Lines end at a newline byte or at a byte flagged chunk_end; fields are
// split by semicolons. An 'e' line sets the left and right encoder counts from
// fields 1 and 2, a 't' line sets the update microseconds and seconds since
// update, both only when a third field is present.
// The rsp channel carries one transaction per finished line: the line kind,
// the four stored counts after the line and a status for each of the two fields.
// Throughput: one byte per cycle while the line queue has room. The front end
// parses each byte and pushes a record per finished line into a four-entry
// queue; the back end retires one record per cycle into the output register
// while that register is free or being emptied. The record of the byte that
// closes a line is written into the queue, then moved into the output
// register, which raises rsp_valid. Reset returns the line state to its start,
// empties the queue, drops rsp_valid and clears all four stored counts to zero.
// When the receiver stalls, up to four finished lines wait in the queue besides
// the one in the output register; req_ready then drops until a line is taken.
`default_nettype none

module telemetry_line_field_parser
   import tlfp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic         q_full;
   logic         push_valid;
   line_rec_type push_rec;
   logic         pop_valid;
   logic         pop;
   line_rec_type pop_rec;

   // Byte framing and field parsing.
   tlfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_rec   (push_rec)
   );

   // Finished lines waiting for the back end.
   tlfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_rec    (pop_rec)
   );

   // Count updates and result output.
   tlfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_rec    (pop_rec),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/tlfp_front.sv
`default_nettype none

module tlfp_front
   import tlfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type      req_data,
   input  wire logic         q_full,
   output logic              push_valid,
   output line_rec_type      push_rec
);

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   localparam logic [7:0] CH_E = 8'd101;
   localparam logic [7:0] CH_T = 8'd116;
   localparam logic [7:0] CH_PLUS = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO = 8'd48;
   localparam logic [7:0] CH_NINE = 8'd57;

   logic                   at_start_ff, at_start_in;
   kind_type               kind_ff, kind_in;
   logic [1:0]             sep_cnt_ff, sep_cnt_in;
   logic                   third_ff, third_in;
   phase_type              phase_ff, phase_in;
   parse_state_type        parse_ff, parse_in;
   status_type             held_st_ff, held_st_in;
   logic [VALUE_WIDTH-1:0] held_val_ff, held_val_in;

   logic                   accept;
   logic [7:0]             rx;
   logic                   is_nl;
   logic                   is_sep;
   logic                   is_digit;
   logic                   is_space;
   logic [3:0]             digit_val;
   logic [VALUE_WIDTH-1:0] mag_thr;
   logic [VALUE_WIDTH-1:0] mag_x10;
   finish_type             first_fin;

   // The front end stalls only when the line queue has no room.
   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;

   // Byte classification.
   assign rx = req_data.rx_byte;
   assign is_nl = (rx == CH_NL);
   assign is_sep = (rx == CH_SEP);
   assign is_digit = (rx >= CH_ZERO) && (rx <= CH_NINE);
   assign is_space = rx inside {8'd32, [8'd9:8'd13]};
   assign digit_val = 4'(rx - CH_ZERO);

   // Overflow limit for the next digit and the shifted accumulator.
   assign mag_thr = MAG_DIV10 - VALUE_WIDTH'(digit_val > MAG_MOD10);
   assign mag_x10 = (parse_ff.mag << 3) + (parse_ff.mag << 1);
   assign first_fin = parse_finish(parse_ff);

   // Line and field state update for one accepted byte.
   always_comb begin
      at_start_in = at_start_ff;
      kind_in = kind_ff;
      sep_cnt_in = sep_cnt_ff;
      third_in = third_ff;
      phase_in = phase_ff;
      parse_in = parse_ff;
      held_st_in = held_st_ff;
      held_val_in = held_val_ff;
      push_valid = 1'b0;
      push_rec = '0;

      if (accept) begin
         if (!is_nl) begin
            if (at_start_ff) begin
               at_start_in = 1'b0;
               if (rx == CH_E) begin
                  kind_in = KIND_ENC;
               end else if (rx == CH_T) begin
                  kind_in = KIND_TIME;
               end else begin
                  kind_in = KIND_OTHER;
               end
            end
            if (sep_cnt_ff == 2'd2) begin
               third_in = 1'b1;
            end
            if (is_sep) begin
               if (sep_cnt_ff == 2'd1) begin
                  held_st_in = first_fin.status;
                  held_val_in = first_fin.value;
               end
               if (sep_cnt_ff < 2'd2) begin
                  phase_in = PH_SPACE;
                  parse_in = '0;
               end
               if (sep_cnt_ff < 2'd3) begin
                  sep_cnt_in = sep_cnt_ff + 2'd1;
               end
            end else if (sep_cnt_ff == 2'd1 || sep_cnt_ff == 2'd2) begin
               case (phase_ff)
                  PH_SPACE: begin
                     if (is_space) begin
                        phase_in = PH_SPACE;
                     end else if (rx == CH_PLUS || rx == CH_MINUS) begin
                        parse_in.minus = (rx == CH_MINUS);
                        phase_in = PH_SIGN;
                     end else if (is_digit) begin
                        parse_in.digit = 1'b1;
                        if (!parse_ff.ovf) begin
                           if (parse_ff.mag > mag_thr) begin
                              parse_in.ovf = 1'b1;
                           end else begin
                              parse_in.mag = mag_x10 + VALUE_WIDTH'(digit_val);
                           end
                        end
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  PH_SIGN, PH_DIGITS: begin
                     if (is_digit) begin
                        parse_in.digit = 1'b1;
                        if (!parse_ff.ovf) begin
                           if (parse_ff.mag > mag_thr) begin
                              parse_in.ovf = 1'b1;
                           end else begin
                              parse_in.mag = mag_x10 + VALUE_WIDTH'(digit_val);
                           end
                        end
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end

         // A newline closes the line as it stands; chunk end closes it after this byte.
         if (is_nl || req_data.chunk_end) begin
            push_valid = 1'b1;
            push_rec.kind = kind_in;
            push_rec.applied = (kind_in != KIND_OTHER) && third_in;
            push_rec.first_status = held_st_in;
            push_rec.first_value = held_val_in;
            push_rec.field2 = parse_in;

            at_start_in = 1'b1;
            kind_in = KIND_OTHER;
            sep_cnt_in = 2'd0;
            third_in = 1'b0;
            phase_in = PH_SPACE;
            parse_in = '0;
            held_st_in = ST_OK;
            held_val_in = '0;
         end
      end
   end

   // Line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         kind_ff <= KIND_OTHER;
         sep_cnt_ff <= 2'd0;
         third_ff <= 1'b0;
         phase_ff <= PH_SPACE;
         parse_ff <= '0;
         held_st_ff <= ST_OK;
         held_val_ff <= '0;
      end else begin
         at_start_ff <= at_start_in;
         kind_ff <= kind_in;
         sep_cnt_ff <= sep_cnt_in;
         third_ff <= third_in;
         phase_ff <= phase_in;
         parse_ff <= parse_in;
         held_st_ff <= held_st_in;
         held_val_ff <= held_val_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tlfp_queue.sv
`default_nettype none

module tlfp_queue
   import tlfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire line_rec_type  push_rec,
   output logic               full,
   output logic               pop_valid,
   input  wire logic          pop,
   output line_rec_type       pop_rec
);

   line_rec_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_rec = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && pop_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tlfp_back.sv
`default_nettype none

module tlfp_back
   import tlfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pop_valid,
   input  wire line_rec_type  pop_rec,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data
);

   logic [VALUE_WIDTH-1:0] left_ff, left_in;
   logic [VALUE_WIDTH-1:0] right_ff, right_in;
   logic [VALUE_WIDTH-1:0] micros_ff, micros_in;
   logic [VALUE_WIDTH-1:0] seconds_ff, seconds_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff, rsp_data_in;
   finish_type             second_fin;
   status_type             s1;
   status_type             s2;

   // Take a line whenever the output register is free or being emptied.
   assign pop = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign second_fin = parse_finish(pop_rec.field2);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Register updates and the result of the line at the queue head.
   always_comb begin
      left_in = left_ff;
      right_in = right_ff;
      micros_in = micros_ff;
      seconds_in = seconds_ff;
      s1 = ST_NOT_APPLIED;
      s2 = ST_NOT_APPLIED;
      if (pop_rec.applied) begin
         s1 = pop_rec.first_status;
         s2 = second_fin.status;
         if (pop_rec.kind == KIND_ENC) begin
            if (s1 == ST_OK) begin
               left_in = pop_rec.first_value;
            end
            if (s2 == ST_OK) begin
               right_in = second_fin.value;
            end
         end else begin
            if (s1 == ST_OK) begin
               micros_in = pop_rec.first_value;
            end
            if (s2 == ST_OK) begin
               seconds_in = second_fin.value;
            end
         end
      end
      rsp_data_in.line_kind = pop_rec.kind;
      rsp_data_in.left_count = OUT_WIDTH'(signed'(left_in));
      rsp_data_in.right_count = OUT_WIDTH'(signed'(right_in));
      rsp_data_in.update_micros = OUT_WIDTH'(signed'(micros_in));
      rsp_data_in.since_seconds = OUT_WIDTH'(signed'(seconds_in));
      rsp_data_in.first_status = s1;
      rsp_data_in.second_status = s2;
   end

   // Stored counts and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         right_ff <= '0;
         micros_ff <= '0;
         seconds_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         left_ff <= left_in;
         right_ff <= right_in;
         micros_ff <= micros_in;
         seconds_ff <= seconds_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tlfp_checker.sv
`default_nettype none

module tlfp_checker
   import tlfp_pkg::*;
(
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready,
   input wire rsp_type  rsp_data
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // No result is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A line of another kind never applies its fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_kind == KIND_OTHER |->
         rsp_data.first_status == ST_NOT_APPLIED &&
         rsp_data.second_status == ST_NOT_APPLIED)
      else $error("fields applied on a line of another kind");

   // Both fields are applied together or not at all.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.first_status == ST_NOT_APPLIED) ==
         (rsp_data.second_status == ST_NOT_APPLIED))
      else $error("only one field marked as not applied");

endmodule

bind telemetry_line_field_parser tlfp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
